@@ src/pec_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_pkg
// Shared types, codes and sizes of the eBPF program preflight checker.
// ----------------------------------------------------------------------------
package pec_pkg;

    localparam int MAX_SLOTS = 4096;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int PB_W      = 16;
    localparam int CNT_W     = PB_W - 3;
    localparam int OFF_W     = 16;
    localparam int IMM_W     = 32;
    localparam int HELPER_W  = 64;
    localparam int HSEL_W    = $clog2(HELPER_W);
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;
    localparam int JW_A      = (SLOT_W + 1 > OFF_W) ? SLOT_W + 1 : OFF_W;
    localparam int JW        = ((JW_A > CNT_W + 1) ? JW_A : CNT_W + 1) + 1;

    localparam logic [7:0] OP_WIDE_LOAD = 8'h18;
    localparam logic [7:0] OP_CALL      = 8'h85;
    localparam logic [7:0] OP_EXIT      = 8'h95;
    localparam logic [2:0] CLASS_MASK   = 3'h7;
    localparam logic [2:0] CLASS_JMP    = 3'h5;
    localparam logic [3:0] REG_LIMIT    = 4'd11;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BUSY     = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_BAD_REG  = 3'd3,
        ST_BAD_JUMP = 3'd4,
        ST_BAD_CALL = 3'd5,
        ST_NO_RET   = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROGRAM_BYTES   = 2'd0,
        CFG_ALLOW_NO_RET    = 2'd1,
        CFG_ALLOWED_HELPERS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [PB_W-1:0]     program_bytes;
        logic                allow_missing_return;
        logic [HELPER_W-1:0] allowed_helpers;
    } t_cfg;

    typedef struct packed {
        logic [7:0]              opcode;
        logic [3:0]              dst_reg;
        logic [3:0]              src_reg;
        logic signed [OFF_W-1:0] jump_offset;
        logic [IMM_W-1:0]        immediate;
    } t_slot;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic              skip_next_slot;
        t_status           error_code;
        logic              verified;
    } t_pass_state;

    typedef struct packed {
        t_status status;
        logic    final_res;
    } t_result;

endpackage

@@ src/pec_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_cfg_regs
// Configuration register file; flags a program length write.
// ----------------------------------------------------------------------------
module pec_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr,
    input  logic [pec_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [pec_pkg::CFG_DAT_W-1:0] i_data,
    output pec_pkg::t_cfg              o_cfg,
    output logic                       o_len_wr
);
    import pec_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic n_len_wr;

    always_comb begin
        n_cfg    = r_cfg;
        n_len_wr = 1'b0;
        if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_PROGRAM_BYTES: begin
                    n_cfg.program_bytes = i_data[PB_W-1:0];
                    n_len_wr            = 1'b1;
                end
                CFG_ALLOW_NO_RET: begin
                    n_cfg.allow_missing_return = i_data[0];
                end
                CFG_ALLOWED_HELPERS: begin
                    n_cfg.allowed_helpers = i_data[HELPER_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg    = r_cfg;
    assign o_len_wr = n_len_wr;

endmodule

@@ src/pec_slot_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_slot_check
// Checks one instruction slot against the pass state; gives result and next state.
// ----------------------------------------------------------------------------
module pec_slot_check (
    input  pec_pkg::t_cfg        i_cfg,
    input  pec_pkg::t_pass_state i_state,
    input  pec_pkg::t_slot       i_slot,
    output pec_pkg::t_pass_state o_state,
    output pec_pkg::t_result     o_result
);
    import pec_pkg::*;

    logic [CNT_W-1:0]     w_slots;
    logic                 w_bad_len;
    logic                 w_last;
    logic signed [JW-1:0] w_target;
    logic                 w_bad_jump;
    logic                 w_bad_call;
    logic                 w_bad_reg;

    assign w_slots   = i_cfg.program_bytes[PB_W-1:3];
    assign w_bad_len = (i_cfg.program_bytes == '0) || (i_cfg.program_bytes[2:0] != 3'd0)
                       || (JW'(w_slots) > JW'(MAX_SLOTS));
    assign w_last    = (JW'(i_state.slot_index) + JW'(1)) >= JW'(w_slots);
    assign w_target  = $signed(JW'(i_state.slot_index)) + JW'(i_slot.jump_offset);
    assign w_bad_jump = w_target[JW-1] || (w_target >= $signed(JW'(w_slots)));
    assign w_bad_call = (i_slot.immediate[IMM_W-1:HSEL_W] != '0)
                        || !i_cfg.allowed_helpers[i_slot.immediate[HSEL_W-1:0]];
    assign w_bad_reg  = (i_slot.dst_reg >= REG_LIMIT) || (i_slot.src_reg >= REG_LIMIT);

    always_comb begin
        t_pass_state v_st;
        t_status     v_err;

        v_st  = i_state;
        v_err = i_state.error_code;
        o_result.status    = ST_OK;
        o_result.final_res = 1'b1;
        if (i_state.verified) begin
            o_result.status = ST_OK;
        end else if (w_bad_len) begin
            o_result.status = ST_BAD_LEN;
        end else begin
            if (i_state.error_code == ST_OK) begin
                if (i_state.skip_next_slot) begin
                    v_st.skip_next_slot = 1'b0;
                end else if (w_bad_reg) begin
                    v_err = ST_BAD_REG;
                end else if (i_slot.opcode == OP_WIDE_LOAD) begin
                    v_st.skip_next_slot = 1'b1;
                end else if ((i_slot.opcode[2:0] & CLASS_MASK) == CLASS_JMP && w_bad_jump) begin
                    v_err = ST_BAD_JUMP;
                end else if (i_slot.opcode == OP_CALL && w_bad_call) begin
                    v_err = ST_BAD_CALL;
                end
            end
            if (!w_last) begin
                o_result.status    = (v_err != ST_OK) ? v_err : ST_BUSY;
                o_result.final_res = 1'b0;
                v_st.error_code    = v_err;
                v_st.slot_index    = i_state.slot_index + SLOT_W'(1);
            end else begin
                if (v_err == ST_OK && i_slot.opcode != OP_EXIT
                        && !i_cfg.allow_missing_return) begin
                    v_err = ST_NO_RET;
                end
                o_result.status     = v_err;
                v_st.verified       = (v_err == ST_OK);
                v_st.slot_index     = '0;
                v_st.skip_next_slot = 1'b0;
                v_st.error_code     = ST_OK;
            end
        end
        o_state = v_st;
    end

endmodule

@@ src/ebpf_program_preflight_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebpf_program_preflight_checker
// Streaming preflight check of an eBPF program, one instruction slot per beat.
// ----------------------------------------------------------------------------
// Takes one instruction slot per clock and presents one result beat per slot
// from the result register; the check runs in a single pass of logic between
// the input register and the result register, so a new slot enters every
// cycle unless the result side stalls. The configuration port is always
// ready and needs no clearing pass after reset; write it only while idle.
module ebpf_program_preflight_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pec_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_opcode,
    input  logic [3:0]                     i_dst_reg,
    input  logic [3:0]                     i_src_reg,
    input  logic signed [pec_pkg::OFF_W-1:0] i_jump_offset,
    input  logic [pec_pkg::IMM_W-1:0]      i_immediate,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_status,
    output logic                           o_final_res
);
    import pec_pkg::*;

    t_cfg        w_cfg;
    logic        w_len_wr;
    logic        w_out_adv;
    logic        w_in_take;
    t_pass_state w_nxt_state;
    t_result     w_result;

    logic        r_in_vld;
    t_slot       r_slot;
    t_pass_state r_state;
    logic        r_out_vld;
    t_result     r_out;

    assign o_cfg_ready = 1'b1;

    pec_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (i_cfg_valid),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_cfg    (w_cfg),
        .o_len_wr (w_len_wr)
    );

    pec_slot_check u_check (
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .i_slot   (r_slot),
        .o_state  (w_nxt_state),
        .o_result (w_result)
    );

    assign w_out_adv = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_out_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_out_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_slot.opcode      <= i_opcode;
            r_slot.dst_reg     <= i_dst_reg;
            r_slot.src_reg     <= i_src_reg;
            r_slot.jump_offset <= i_jump_offset;
            r_slot.immediate   <= i_immediate;
        end
    end

    // pass state: a length write restarts the pass and drops the verified flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_len_wr) begin
            r_state <= '0;
        end else if (w_out_adv) begin
            r_state <= w_nxt_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_adv) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_status    = r_out.status;
    assign o_final_res = r_out.final_res;

`ifndef ASSERT_OFF
    a_busy_not_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BUSY) |-> !o_final_res)
        else $error("in-progress status marked as final");

    a_len_wr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == CFG_PROGRAM_BYTES) |=> !r_state.verified)
        else $error("verified flag survived a length write");

    a_skip_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skip_next_slot |-> (r_state.error_code == ST_OK))
        else $error("skip pending with an error latched");
`endif

endmodule

@@ dv/pec_verdict_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_verdict_checker
// Watches the configuration, slot and result channels of the eBPF program
// preflight checker. Tracks the pass state itself, works out the status beat
// each accepted slot should produce and compares the result beats in order.
// ----------------------------------------------------------------------------
module pec_verdict_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [pec_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pec_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [7:0]                       i_opcode,
    input  logic [3:0]                       i_dst_reg,
    input  logic [3:0]                       i_src_reg,
    input  logic signed [pec_pkg::OFF_W-1:0] i_jump_offset,
    input  logic [pec_pkg::IMM_W-1:0]        i_immediate,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [2:0]                       i_status,
    input  logic                             i_final_res,
    output int                               o_mismatches,
    output int                               o_pending
);
    import pec_pkg::*;

    logic [PB_W-1:0]     len_bytes;
    logic                allow_no_exit;
    logic [HELPER_W-1:0] helper_map;
    int                  slot_pos;
    logic                skip_pending;
    t_status             latched_err;
    logic                pass_ok;
    t_result             verdicts_due[$];

    function automatic t_result predict_verdict(input t_slot s);
        t_result r;
        int      slots;
        int      target;
        slots = int'(len_bytes) >> 3;
        r.final_res = 1'b1;
        if (pass_ok) begin
            r.status = ST_OK;
            return r;
        end
        if (len_bytes == '0 || len_bytes[2:0] != 3'd0 || slots > MAX_SLOTS) begin
            r.status = ST_BAD_LEN;
            return r;
        end
        if (latched_err == ST_OK) begin
            target = slot_pos + int'($signed(s.jump_offset));
            if (skip_pending) begin
                skip_pending = 1'b0;
            end else if (s.dst_reg >= REG_LIMIT || s.src_reg >= REG_LIMIT) begin
                latched_err = ST_BAD_REG;
            end else if (s.opcode == OP_WIDE_LOAD) begin
                skip_pending = 1'b1;
            end else if (s.opcode[2:0] == CLASS_JMP && (target < 0 || target >= slots)) begin
                latched_err = ST_BAD_JUMP;
            end else if (s.opcode == OP_CALL && (s.immediate >= HELPER_W ||
                         !helper_map[s.immediate[HSEL_W-1:0]])) begin
                latched_err = ST_BAD_CALL;
            end
        end
        if (slot_pos + 1 < slots) begin
            r.status = (latched_err == ST_OK) ? ST_BUSY : latched_err;
            r.final_res = 1'b0;
            slot_pos = slot_pos + 1;
            return r;
        end
        r.status = latched_err;
        if (r.status == ST_OK && s.opcode != OP_EXIT && !allow_no_exit) begin
            r.status = ST_NO_RET;
        end
        if (r.status == ST_OK) begin
            pass_ok = 1'b1;
        end
        slot_pos = 0;
        skip_pending = 1'b0;
        latched_err = ST_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_slot   s;
        t_result due;
        if (!i_rst_n) begin
            len_bytes = '0;
            allow_no_exit = 1'b0;
            helper_map = '0;
            slot_pos = 0;
            skip_pending = 1'b0;
            latched_err = ST_OK;
            pass_ok = 1'b0;
            verdicts_due.delete();
            o_mismatches = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROGRAM_BYTES: begin
                        len_bytes = i_cfg_data[PB_W-1:0];
                        pass_ok = 1'b0;
                        slot_pos = 0;
                        skip_pending = 1'b0;
                        latched_err = ST_OK;
                    end
                    CFG_ALLOW_NO_RET: begin
                        allow_no_exit = i_cfg_data[0];
                    end
                    CFG_ALLOWED_HELPERS: begin
                        helper_map = i_cfg_data[HELPER_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (verdicts_due.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    if (o_mismatches <= 10) begin
                        $display("%0t: result beat with nothing due: status %0d final_res %0b",
                                 $time, i_status, i_final_res);
                    end
                end else begin
                    due = verdicts_due.pop_front();
                    if (i_status !== due.status || i_final_res !== due.final_res) begin
                        o_mismatches = o_mismatches + 1;
                        if (o_mismatches <= 10) begin
                            $display("%0t: mismatch: status exp %0d got %0d, final_res exp %0b got %0b",
                                     $time, due.status, i_status, due.final_res, i_final_res);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                s.opcode = i_opcode;
                s.dst_reg = i_dst_reg;
                s.src_reg = i_src_reg;
                s.jump_offset = i_jump_offset;
                s.immediate = i_immediate;
                verdicts_due.push_back(predict_verdict(s));
            end
            o_pending = verdicts_due.size();
        end
    end

endmodule

@@ dv/tb_ebpf_program_preflight_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ebpf_program_preflight_checker
// Drives instruction slots and configuration writes into the preflight
// checker: a directed set of length, register, jump, call, wide-load and exit
// cases, the start of a full-size program, then random programs, mostly well
// formed, under random idling on both channels. The verdict checker scores
// each beat.
// ----------------------------------------------------------------------------
module tb_ebpf_program_preflight_checker;
    import pec_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_ITEMS   = 500;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic [7:0] OP_JA       = 8'h05;
    localparam logic [7:0] OP_ADD64    = 8'h07;
    localparam logic [7:0] OP_MOV64    = 8'hb7;
    localparam logic [7:0] OP_ALL_ONES = 8'hff;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DAT_W-1:0]     i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [7:0]               i_opcode;
    logic [3:0]               i_dst_reg;
    logic [3:0]               i_src_reg;
    logic signed [OFF_W-1:0]  i_jump_offset;
    logic [IMM_W-1:0]         i_immediate;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [2:0]               o_status;
    logic                     o_final_res;

    int                  mismatches;
    int                  pending;
    int                  cycle_count = 0;
    int                  stall_left = 0;
    int                  random_items;
    bit                  idle_on;
    bit                  cur_allow;
    logic [HELPER_W-1:0] cur_helpers;

    ebpf_program_preflight_checker DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_dst_reg     (i_dst_reg),
        .i_src_reg     (i_src_reg),
        .i_jump_offset (i_jump_offset),
        .i_immediate   (i_immediate),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_final_res   (o_final_res)
    );

    pec_verdict_checker u_verdict_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_dst_reg     (i_dst_reg),
        .i_src_reg     (i_src_reg),
        .i_jump_offset (i_jump_offset),
        .i_immediate   (i_immediate),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_final_res   (o_final_res),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("ebpf_program_preflight_checker test failed");
            $finish;
        end
    end

    // hold the result side in bursts
    always @(negedge i_clk) begin
        if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6);
        end
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic t_slot make_slot(input logic [7:0] op, input logic [3:0] dst,
                                        input logic [3:0] src, input int off,
                                        input logic [31:0] imm);
        t_slot s;
        s.opcode = op;
        s.dst_reg = dst;
        s.src_reg = src;
        s.jump_offset = 16'(off);
        s.immediate = imm;
        return s;
    endfunction

    function automatic t_slot rand_slot();
        t_slot s;
        s.opcode = 8'($urandom);
        s.dst_reg = 4'($urandom);
        s.src_reg = 4'($urandom);
        s.jump_offset = 16'($urandom);
        s.immediate = $urandom;
        return s;
    endfunction

    // well-formed slot at position idx of a program of the given length
    function automatic t_slot build_slot(input int idx, input int slots);
        t_slot s;
        int    kind;
        int    hb;
        s = rand_slot();
        s.dst_reg = 4'($urandom_range(0, 10));
        s.src_reg = 4'($urandom_range(0, 10));
        s.jump_offset = 16'(int'($urandom_range(0, slots - 1)) - idx);
        kind = (idx == slots - 1 && !cur_allow) ? 9 : $urandom_range(0, 9);
        if (kind < 4) begin
            do s.opcode = 8'($urandom);
            while (s.opcode[2:0] == CLASS_JMP || s.opcode == OP_WIDE_LOAD);
        end else if (kind < 6) begin
            do s.opcode = {5'($urandom), CLASS_JMP};
            while (s.opcode == OP_CALL);
        end else if (kind == 6 && cur_helpers != '0) begin
            do hb = $urandom_range(0, HELPER_W - 1);
            while (!cur_helpers[hb]);
            s.opcode = OP_CALL;
            s.immediate = 32'(hb);
        end else if (kind == 7) begin
            s.opcode = OP_WIDE_LOAD;
        end else begin
            s.opcode = OP_EXIT;
        end
        return s;
    endfunction

    task automatic send_slot(input t_slot s);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= s.opcode;
        i_dst_reg <= s.dst_reg;
        i_src_reg <= s.src_reg;
        i_jump_offset <= s.jump_offset;
        i_immediate <= s.immediate;
        do @(posedge i_clk);
        while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic configure(input logic [PB_W-1:0] bytes, input bit allow,
                             input logic [HELPER_W-1:0] helpers);
        drain();
        cfg_write(CFG_PROGRAM_BYTES, {$urandom, 16'($urandom), bytes});
        cfg_write(CFG_ALLOW_NO_RET, {$urandom, 31'($urandom), allow});
        cfg_write(CFG_ALLOWED_HELPERS, helpers);
        if ($urandom_range(0, 7) == 0) begin
            cfg_write(CFG_SPARE, {$urandom, $urandom});
        end
        i_cfg_valid <= 1'b0;
        cur_allow = allow;
        cur_helpers = helpers;
    endtask

    task automatic run_program_pass(input int slots, input bit broken, input bit noisy);
        int    bad_at;
        int    idx;
        bit    skip;
        t_slot s;
        bad_at = $urandom_range(0, slots - 1);
        skip = 1'b0;
        for (idx = 0; idx < slots; idx++) begin
            if (noisy) begin
                s = rand_slot();
            end else if (skip) begin
                s = rand_slot();
                if (idx == slots - 1 && !cur_allow) begin
                    s.opcode = OP_EXIT;
                end
            end else begin
                s = build_slot(idx, slots);
            end
            if (broken && idx == bad_at) begin
                case ($urandom_range(0, 4))
                    0: s.dst_reg = 4'($urandom_range(11, 15));
                    1: s.src_reg = 4'($urandom_range(11, 15));
                    2: begin
                        s.opcode = {5'($urandom), CLASS_JMP};
                        s.jump_offset = 16'($urandom);
                    end
                    3: begin
                        s.opcode = OP_CALL;
                        s.immediate = $urandom;
                    end
                    default: s.opcode = 8'($urandom);
                endcase
            end
            skip = !skip && s.opcode == OP_WIDE_LOAD;
            send_slot(s);
            random_items++;
        end
    endtask

    initial begin
        logic [PB_W-1:0]     bytes;
        logic [HELPER_W-1:0] helpers;
        int                  npass;
        int                  k;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_opcode = '0;
        i_dst_reg = '0;
        i_src_reg = '0;
        i_jump_offset = '0;
        i_immediate = '0;
        i_out_stall = 1'b0;
        idle_on = 1'b1;
        cur_allow = 1'b0;
        cur_helpers = '0;
        random_items = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // length faults: zero after reset, not a multiple of eight, too long
        send_slot(make_slot(OP_EXIT, 0, 0, 0, 0));
        configure(16'd5, 1'b0, '0);
        send_slot(make_slot(OP_EXIT, 0, 0, 0, 0));
        configure(16'hfff8, 1'b1, '1);
        send_slot(rand_slot());

        // single-slot program, then the verified short cut
        configure(16'd8, 1'b0, '0);
        send_slot(make_slot(OP_EXIT, 10, 10, 0, 0));
        send_slot(rand_slot());
        configure(16'd8, 1'b0, '0);
        send_slot(make_slot(OP_ADD64, 0, 0, 0, 0));

        configure(16'd32, 1'b0, 64'h8000_0000_0000_0001);
        send_slot(make_slot(OP_JA, 0, 0, 3, 0));
        send_slot(make_slot(OP_WIDE_LOAD, 0, 0, 0, 0));
        send_slot(make_slot(OP_ALL_ONES, 15, 15, -1, '1));
        send_slot(make_slot(OP_EXIT, 0, 0, -3, 0));

        configure(16'd32, 1'b0, 64'h8000_0000_0000_0001);
        send_slot(make_slot(OP_CALL, 0, 0, 0, 63));
        send_slot(make_slot(OP_CALL, 0, 0, 0, 64));
        send_slot(make_slot(OP_MOV64, 15, 0, 0, 0));
        send_slot(make_slot(OP_EXIT, 0, 0, 0, 0));
        send_slot(make_slot(OP_JA, 0, 0, -32768, 0));
        send_slot(make_slot(OP_CALL, 0, 0, 0, '1));
        send_slot(rand_slot());
        send_slot(make_slot(OP_EXIT, 0, 0, 0, 0));
        send_slot(make_slot(OP_JA, 0, 11, 32767, 0));
        send_slot(make_slot(OP_MOV64, 0, 0, 0, 0));
        send_slot(make_slot(OP_MOV64, 0, 0, 0, 0));
        send_slot(make_slot(OP_EXIT, 0, 0, 1, 0));

        // exit rule on the skipped half of a wide load, and its waiver
        configure(16'd16, 1'b0, '0);
        send_slot(make_slot(OP_WIDE_LOAD, 0, 0, 0, 0));
        send_slot(make_slot(OP_EXIT, 15, 15, 0, 0));
        configure(16'd16, 1'b0, '0);
        send_slot(make_slot(OP_WIDE_LOAD, 0, 0, 0, 0));
        send_slot(make_slot(OP_ADD64, 0, 0, 0, 0));
        configure(16'd16, 1'b1, '0);
        send_slot(make_slot(OP_MOV64, 0, 0, 0, 0));
        send_slot(make_slot(OP_ADD64, 0, 0, 0, 0));

        // largest length the block accepts: open a pass and leave it unfinished
        configure(16'(MAX_SLOTS * 8), 1'b0, {$urandom, $urandom});
        for (k = 0; k < 8; k++) begin
            send_slot(build_slot(k, MAX_SLOTS));
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            drain();
            idle_on = (random_items < CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0: helpers = {$urandom, $urandom};
                1: helpers = '1;
                2: helpers = '0;
                default: helpers = 64'd1 << $urandom_range(0, HELPER_W - 1);
            endcase
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 2))
                    0: bytes = '0;
                    1: bytes = {13'($urandom), 3'($urandom_range(1, 7))};
                    default: bytes = 16'h8000 | 16'($urandom_range(1, MAX_SLOTS - 1) << 3);
                endcase
                configure(bytes, 1'($urandom), helpers);
                repeat ($urandom_range(1, 4)) begin
                    send_slot(rand_slot());
                    random_items++;
                end
            end else begin
                if ($urandom_range(0, 19) == 0) begin
                    bytes = 16'($urandom_range(1, 64) * 8);
                end else begin
                    bytes = 16'($urandom_range(1, 12) * 8);
                end
                configure(bytes, 1'($urandom), helpers);
                npass = $urandom_range(1, 3);
                repeat (npass) begin
                    run_program_pass(int'(bytes) >> 3, $urandom_range(0, 3) == 0,
                                     $urandom_range(0, 9) == 0);
                end
            end
        end

        idle_on = 1'b0;
        drain();
        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("ebpf_program_preflight_checker test passed");
        end else begin
            $display("ebpf_program_preflight_checker test failed");
        end
        $finish;
    end

endmodule
